### src/periodic_wrap_with_image_count_assert.svh
// Assertion macros shared by the wrap block; each use expands to one
// labeled concurrent assertion clocked on the rising edge, reset-gated.
`ifndef PERIODIC_WRAP_WITH_IMAGE_COUNT_ASSERT_SVH
`define PERIODIC_WRAP_WITH_IMAGE_COUNT_ASSERT_SVH

// Same-cycle implication
`define PWIC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PWIC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pwic_pkg.sv
// ----------------------------------------------------------------------------
// pwic_pkg
// Widths, register codes, reset values and saturating arithmetic for the
// periodic boundary wrap block.
// ----------------------------------------------------------------------------
package pwic_pkg;

    localparam int COORD_BITS     = 32;
    localparam int COUNTER_BITS   = 10;
    localparam int FRAC_BITS      = 16;
    localparam int NUM_DIMS       = 3;
    localparam int IMAGE_BITS     = NUM_DIMS * COUNTER_BITS;
    localparam int PAYLOAD_BITS   = NUM_DIMS * COORD_BITS + IMAGE_BITS;
    localparam int TDATA_BITS     = ((PAYLOAD_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COUNTER_BITS-1:0]      count_t;
    typedef logic [IMAGE_BITS-1:0]        image_t;
    typedef logic [NUM_DIMS-1:0]          dim_mask_t;

    // Register codes in write-port order
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LOW_X,
        REG_LOW_Y,
        REG_LOW_Z,
        REG_HIGH_X,
        REG_HIGH_Y,
        REG_HIGH_Z,
        REG_PERIODIC_MASK,
        REG_LAMDA_MODE
    } cfg_reg_t;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam coord_t COORD_MIN = ~COORD_MAX;

    // 1.0 in fixed point, or the largest value if it does not fit
    localparam coord_t LAMDA_ONE = (FRAC_BITS < COORD_BITS - 1) ?
                                   coord_t'(coord_t'(1) <<< FRAC_BITS) : COORD_MAX;

    localparam coord_t    LOW_RESET  = coord_t'(-32768);
    localparam coord_t    HIGH_RESET = coord_t'(32768);
    localparam dim_mask_t MASK_RESET = '1;

    // Add with saturation to the signed coordinate range
    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic [COORD_BITS:0] sum;
        sum = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        if (sum[COORD_BITS] != sum[COORD_BITS-1]) begin
            return sum[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end
        return coord_t'(sum[COORD_BITS-1:0]);
    endfunction

    // Subtract with saturation to the signed coordinate range
    function automatic coord_t sat_sub(coord_t a, coord_t b);
        logic [COORD_BITS:0] diff;
        diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (diff[COORD_BITS] != diff[COORD_BITS-1]) begin
            return diff[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end
        return coord_t'(diff[COORD_BITS-1:0]);
    endfunction

endpackage

### src/periodic_wrap_with_image_count.sv
// ----------------------------------------------------------------------------
// periodic_wrap_with_image_count: periodic boundary wrap with image counters
// Each accepted item passes through the input, stage 1, stage 2 and output registers before its result is valid.
// Throughput: one item per cycle, set by the four-register datapath pipeline, while m_tready is high and cfg_valid low.
// Reset (aresetn low, synchronous) empties the pipeline, restores registers.
// ----------------------------------------------------------------------------
`include "periodic_wrap_with_image_count_assert.svh"

module periodic_wrap_with_image_count (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pwic_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pwic_pkg::COORD_BITS-1:0]       cfg_data,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pos_x, pos_y, pos_z, image_in, zero pad (lowest bit up)
    input  logic [pwic_pkg::TDATA_BITS-1:0]       s_tdata,
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // wrapped_x, wrapped_y, wrapped_z, image_out, zero pad (lowest bit up)
    output logic [pwic_pkg::TDATA_BITS-1:0]       m_tdata
);

    localparam int ND = pwic_pkg::NUM_DIMS;
    localparam int CB = pwic_pkg::COUNTER_BITS;
    localparam int XB = pwic_pkg::COORD_BITS;

    // Configuration registers
    pwic_pkg::coord_t    low_reg  [ND];
    pwic_pkg::coord_t    high_reg [ND];
    pwic_pkg::dim_mask_t periodic_mask_reg;
    logic                lamda_mode_reg;

    // Effective bounds and period, refreshed from the registers every cycle
    pwic_pkg::coord_t lo_eff_reg [ND];
    pwic_pkg::coord_t hi_eff_reg [ND];
    pwic_pkg::coord_t period_reg [ND];

    // Pipeline stages
    logic             v0_reg, v1_reg, v2_reg, m_tvalid_reg;
    pwic_pkg::coord_t x0_reg [ND];
    pwic_pkg::coord_t x1_reg [ND];
    pwic_pkg::coord_t x2_reg [ND];
    pwic_pkg::coord_t out_x_reg [ND];
    pwic_pkg::image_t img0_reg, img1_reg, img2_reg, out_img_reg;
    pwic_pkg::dim_mask_t above2_reg;

    pwic_pkg::coord_t    x1_next [ND];
    pwic_pkg::coord_t    x2_next [ND];
    pwic_pkg::coord_t    out_x_next [ND];
    pwic_pkg::image_t    img1_next, img2_next;
    pwic_pkg::dim_mask_t above2_next;

    logic out_ready, s2_ready, s1_ready, in_ready;
    logic in_load, s1_load, s2_load, out_load;

    // Stage-to-stage flow control: a stage moves when the next one has room
    assign out_ready = !m_tvalid_reg || m_tready;
    assign s2_ready  = !v2_reg || out_ready;
    assign s1_ready  = !v1_reg || s2_ready;
    assign in_ready  = !v0_reg || s1_ready;

    // Hold off items in a cycle that carries a configuration write
    assign cfg_ready = 1'b1;
    assign s_tready  = in_ready && !cfg_valid;

    assign in_load  = s_tvalid && s_tready;
    assign s1_load  = v0_reg && s1_ready;
    assign s2_load  = v1_reg && s2_ready;
    assign out_load = v2_reg && out_ready;

    // Stage 1: on periodic dimensions, add one period below the low bound, count down
    always_comb begin
        img1_next = img0_reg;
        for (int d = 0; d < ND; d++) begin
            if (periodic_mask_reg[d] && (x0_reg[d] < lo_eff_reg[d])) begin
                x1_next[d] = pwic_pkg::sat_add(x0_reg[d], period_reg[d]);
                img1_next[d*CB +: CB] = img0_reg[d*CB +: CB] - pwic_pkg::count_t'(1);
            end else begin
                x1_next[d] = x0_reg[d];
            end
        end
    end

    // Stage 2: on periodic dimensions, subtract one period at or above the high bound, count up
    always_comb begin
        img2_next   = img1_reg;
        above2_next = '0;
        for (int d = 0; d < ND; d++) begin
            if (periodic_mask_reg[d] && (x1_reg[d] >= hi_eff_reg[d])) begin
                x2_next[d]     = pwic_pkg::sat_sub(x1_reg[d], period_reg[d]);
                above2_next[d] = 1'b1;
                img2_next[d*CB +: CB] = img1_reg[d*CB +: CB] + pwic_pkg::count_t'(1);
            end else begin
                x2_next[d] = x1_reg[d];
            end
        end
    end

    // Stage 3: raise a wrapped-down coordinate to at least the low bound
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            if (above2_reg[d] && (x2_reg[d] < lo_eff_reg[d])) begin
                out_x_next[d] = lo_eff_reg[d];
            end else begin
                out_x_next[d] = x2_reg[d];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < ND; d++) begin
                low_reg[d]  <= pwic_pkg::LOW_RESET;
                high_reg[d] <= pwic_pkg::HIGH_RESET;
            end
            periodic_mask_reg <= pwic_pkg::MASK_RESET;
            lamda_mode_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (pwic_pkg::cfg_reg_t'(cfg_index))
                pwic_pkg::REG_LOW_X:         low_reg[0]  <= pwic_pkg::coord_t'(cfg_data);
                pwic_pkg::REG_LOW_Y:         low_reg[1]  <= pwic_pkg::coord_t'(cfg_data);
                pwic_pkg::REG_LOW_Z:         low_reg[2]  <= pwic_pkg::coord_t'(cfg_data);
                pwic_pkg::REG_HIGH_X:        high_reg[0] <= pwic_pkg::coord_t'(cfg_data);
                pwic_pkg::REG_HIGH_Y:        high_reg[1] <= pwic_pkg::coord_t'(cfg_data);
                pwic_pkg::REG_HIGH_Z:        high_reg[2] <= pwic_pkg::coord_t'(cfg_data);
                pwic_pkg::REG_PERIODIC_MASK: periodic_mask_reg <= cfg_data[ND-1:0];
                pwic_pkg::REG_LAMDA_MODE:    lamda_mode_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Follow the registers: pick bounds by mode, precompute the period
    always_ff @(posedge aclk) begin
        for (int d = 0; d < ND; d++) begin
            if (lamda_mode_reg) begin
                lo_eff_reg[d] <= '0;
                hi_eff_reg[d] <= pwic_pkg::LAMDA_ONE;
                period_reg[d] <= pwic_pkg::sat_sub(pwic_pkg::LAMDA_ONE, '0);
            end else begin
                lo_eff_reg[d] <= low_reg[d];
                hi_eff_reg[d] <= high_reg[d];
                period_reg[d] <= pwic_pkg::sat_sub(high_reg[d], low_reg[d]);
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_ready)  v0_reg       <= in_load;
            if (s1_ready)  v1_reg       <= v0_reg;
            if (s2_ready)  v2_reg       <= v1_reg;
            if (out_ready) m_tvalid_reg <= v2_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (in_load) begin
            for (int d = 0; d < ND; d++) begin
                x0_reg[d] <= pwic_pkg::coord_t'(s_tdata[d*XB +: XB]);
            end
            img0_reg <= s_tdata[ND*XB +: pwic_pkg::IMAGE_BITS];
        end
        if (s1_load) begin
            x1_reg   <= x1_next;
            img1_reg <= img1_next;
        end
        if (s2_load) begin
            x2_reg     <= x2_next;
            img2_reg   <= img2_next;
            above2_reg <= above2_next;
        end
        if (out_load) begin
            out_x_reg   <= out_x_next;
            out_img_reg <= img2_reg;
        end
    end

    // Pack the result
    assign m_tvalid = m_tvalid_reg;
    always_comb begin
        m_tdata = '0;
        for (int d = 0; d < ND; d++) begin
            m_tdata[d*XB +: XB] = out_x_reg[d];
        end
        m_tdata[ND*XB +: pwic_pkg::IMAGE_BITS] = out_img_reg;
    end

    // Checks
    `PWIC_ASSERT_IMP(a_cfg_excl_item, aclk, aresetn, cfg_valid && cfg_ready, !in_load, "item accepted with config write")
    `PWIC_ASSERT_NXT(a_in_lands, aclk, aresetn, in_load, v0_reg, "accepted item lost at input stage")
    `PWIC_ASSERT_NXT(a_s2_hold, aclk, aresetn, v2_reg && !out_ready, v2_reg && $stable(img2_reg), "stalled stage two moved")
    `PWIC_ASSERT_NXT(a_x_fixed, aclk, aresetn, s1_load && !periodic_mask_reg[0], img1_reg[CB-1:0] == $past(img0_reg[CB-1:0]), "x counter moved while not periodic")

endmodule
